// File: design/lbpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpc_pkg
// Shared types and constants of the layer blend pixel combiner.
// ----------------------------------------------------------------------------
package lbpc_pkg;

   localparam int NUM_W    = 24;          // divider numerator width
   localparam int DEN_W    = 17;          // divider denominator width
   localparam int QUO_W    = 8;           // divider quotient width
   localparam int DIV_HALF = QUO_W / 2;   // quotient bits resolved per divider stage
   localparam int NUM_STG  = 9;           // pipeline register stages

   typedef enum logic [3:0] {
      MODE_NORMAL  = 4'd0,
      MODE_ADD     = 4'd1,
      MODE_SUB     = 4'd2,
      MODE_DIFF    = 4'd3,
      MODE_DARKEN  = 4'd4,
      MODE_LIGHTEN = 4'd5,
      MODE_MULT    = 4'd6,
      MODE_DIV     = 4'd7,
      MODE_SCREEN  = 4'd8,
      MODE_OVERLAY = 4'd9,
      MODE_HUE     = 4'd10,
      MODE_SAT     = 4'd11,
      MODE_VALUE   = 4'd12,
      MODE_COLOR   = 4'd13
   } mode_type;

   typedef logic [2:0][7:0] rgb_type;     // [0] red, [1] green, [2] blue

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_in_type;

   localparam div_in_type DIV_NOP = '{num: '0, den: 17'd1};

   // per-stage advance strobes
   typedef struct packed {
      logic p1;
      logic p2;
      logic d1a;
      logic d1b;
      logic p3;
      logic p4;
      logic d2a;
      logic d2b;
      logic p5;
   } adv_type;

   // sideband carried alongside the first divider round
   typedef struct packed {
      logic [3:0] mode;
      rgb_type    src;
      rgb_type    dst;
      logic [7:0] sa;
      logic [7:0] da;
      logic [7:0] na;
      rgb_type    simple;
      logic [7:0] smx;
      logic [7:0] dmx;
      logic [8:0] dsum;
      logic [2:0] rc_hi;
   } side1_type;

   // sideband carried alongside the second divider round
   typedef struct packed {
      logic [3:0] mode;
      rgb_type    dst;
      logic [7:0] da;
      logic [7:0] na;
      logic       sa_zero;
      rgb_type    simple;
      logic [2:0] hi;
      logic [2:0] sector;
      logic       flat;
      logic [7:0] flat_val;
   } side2_type;

endpackage

// File: design/lbpc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpc_div
// Two-stage restoring divider, half the quotient bits per stage.
// Caller guarantees num < den * 2**QUO_W and den != 0.
// ----------------------------------------------------------------------------
module lbpc_div import lbpc_pkg::*; (
   input  logic             clock,
   input  logic             adv_a,
   input  logic             adv_b,
   input  div_in_type       din,
   output logic [QUO_W-1:0] quo
);

   logic [NUM_W-1:0]    rem_a;
   logic [NUM_W-1:0]    rem_ff;
   logic [NUM_W-1:0]    rem_b;
   logic [DEN_W-1:0]    den_ff;
   logic [QUO_W-1:0]    qa_in;
   logic [QUO_W-1:0]    qa_ff;
   logic [QUO_W-1:0]    quo_in;
   logic [QUO_W-1:0]    quo_ff;
   logic [NUM_W:0]      trial_a;
   logic [NUM_W:0]      trial_b;

   always_comb begin
      rem_a = din.num;
      qa_in = '0;
      for (int k = QUO_W - 1; k >= DIV_HALF; k--) begin
         trial_a = (NUM_W + 1)'(din.den) << k;
         if ({1'b0, rem_a} >= trial_a) begin
            rem_a    = rem_a - trial_a[NUM_W-1:0];
            qa_in[k] = 1'b1;
         end
      end
   end

   always_comb begin
      rem_b  = rem_ff;
      quo_in = qa_ff;
      for (int k = DIV_HALF - 1; k >= 0; k--) begin
         trial_b = (NUM_W + 1)'(den_ff) << k;
         if ({1'b0, rem_b} >= trial_b) begin
            rem_b     = rem_b - trial_b[NUM_W-1:0];
            quo_in[k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a) begin
         rem_ff <= rem_a;
         den_ff <= din.den;
         qa_ff  <= qa_in;
      end
      if (adv_b) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

// File: design/lbpc_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpc_prep
// Front stages: byte products, extremes, simple blend modes and the
// operands of the first divider round.
// ----------------------------------------------------------------------------
module lbpc_prep import lbpc_pkg::*; (
   input  logic              clock,
   input  adv_type           adv,
   input  logic [3:0]        mode,
   input  rgb_type           src,
   input  logic [7:0]        src_opacity,
   input  rgb_type           dst,
   input  logic [7:0]        dst_alpha,
   output side1_type         side,
   output div_in_type [3:0]  lane
);

   typedef struct packed {
      logic [3:0] mode;
      rgb_type    s;
      rgb_type    d;
      logic [7:0] sa;
      logic [7:0] da;
      logic [7:0] na;
      rgb_type    ms;
      rgb_type    md;
      rgb_type    scr;
      rgb_type    mc;
      logic [7:0] smx;
      logic [7:0] smn;
      logic [7:0] dmx;
      logic [7:0] dmn;
   } p1_type;

   p1_type            p1_ff, p1_in;
   side1_type         side_ff, side_in;
   div_in_type [3:0]  lane_ff, lane_in;

   logic [2:0][15:0]  scr_prod;
   logic [2:0][15:0]  mc_prod;
   logic [8:0]        na_sum;
   logic [8:0]        t9;
   logic [16:0]       ov;
   div_in_type [2:0]  rc_lane;

   // rounded byte product
   function automatic logic [7:0] mul8(input logic [7:0] a, input logic [7:0] b);
      logic [16:0] t;
      logic [17:0] u;
      t = 17'(a) * 17'(b) + 17'd128;
      u = 18'(t[16:8]) + 18'(t);
      return u[15:8];
   endfunction

   function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      logic [7:0] m;
      m = (a > b) ? a : b;
      if (c > m) m = c;
      return m;
   endfunction

   function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      logic [7:0] m;
      m = (a < b) ? a : b;
      if (c < m) m = c;
      return m;
   endfunction

   // hue in sixths of 255: numerator shifted non-negative, over 2*delta
   function automatic div_in_type hue_lane(input rgb_type c, input logic [7:0] mx,
                                           input logic [7:0] mn);
      div_in_type         r;
      logic [7:0]         dl;
      logic signed [11:0] n;
      logic signed [19:0] nn;
      logic [16:0]        dl510;
      dl    = mx - mn;
      dl510 = 17'(dl) * 17'd510;
      if (c[0] == mx)
         n = $signed({4'b0, c[1]}) - $signed({4'b0, c[2]});
      else if (c[1] == mx)
         n = $signed({3'b0, dl, 1'b0}) + $signed({4'b0, c[2]}) - $signed({4'b0, c[0]});
      else
         n = $signed({2'b0, dl, 2'b0}) + $signed({4'b0, c[0]}) - $signed({4'b0, c[1]});
      nn = 20'(n) * 20'sd85;
      if (nn < 0) nn = nn + $signed({3'b0, dl510});
      r.num = {7'b0, nn[16:0]};
      r.den = {8'b0, dl, 1'b0};
      if (mx == mn) r = DIV_NOP;
      return r;
   endfunction

   function automatic div_in_type hsv_sat_lane(input logic [7:0] mx, input logic [7:0] mn);
      div_in_type r;
      r.num = 24'(mx - mn) * 24'd255;
      r.den = 17'(mx);
      if (mx == mn) r = DIV_NOP;
      return r;
   endfunction

   function automatic div_in_type hls_sat_lane(input logic [7:0] mx, input logic [7:0] mn);
      div_in_type r;
      logic [8:0] sum;
      sum   = 9'(mx) + 9'(mn);
      r.num = 24'(mx - mn) * 24'd255;
      r.den = sum[8] ? 17'(9'd511 - sum) : 17'(sum);
      if (mx == mn) r = DIV_NOP;
      return r;
   endfunction

   // stage 1
   always_comb begin
      p1_in.mode = mode;
      p1_in.s    = src;
      p1_in.d    = dst;
      p1_in.sa   = src_opacity;
      p1_in.da   = dst_alpha;
      for (int c = 0; c < 3; c++) begin
         p1_in.ms[c]  = mul8(src_opacity, src[c]);
         p1_in.md[c]  = mul8(dst[c], 8'd255 - src_opacity);
         scr_prod[c]  = 16'(8'd255 - dst[c]) * 16'(8'd255 - src[c]);
         mc_prod[c]   = 16'(dst[c]) * 16'(src[c]);
         p1_in.scr[c] = 8'd255 - scr_prod[c][15:8];
         p1_in.mc[c]  = mc_prod[c][15:8];
      end
      na_sum = 9'(dst_alpha) + 9'(mul8(8'd255 - dst_alpha, src_opacity));
      if (src_opacity == 8'd255 || na_sum[8])
         p1_in.na = 8'd255;
      else
         p1_in.na = na_sum[7:0];
      p1_in.smx = max3(src[0], src[1], src[2]);
      p1_in.smn = min3(src[0], src[1], src[2]);
      p1_in.dmx = max3(dst[0], dst[1], dst[2]);
      p1_in.dmn = min3(dst[0], dst[1], dst[2]);
   end

   // stage 2
   always_comb begin
      t9 = '0;
      ov = '0;
      for (int c = 0; c < 3; c++) begin
         case (p1_ff.mode)
            MODE_ADD: begin
               t9 = 9'(p1_ff.d[c]) + 9'(p1_ff.ms[c]);
               side_in.simple[c] = t9[8] ? 8'd255 : t9[7:0];
            end
            MODE_SUB: begin
               side_in.simple[c] = (p1_ff.d[c] > p1_ff.ms[c]) ?
                                   p1_ff.d[c] - p1_ff.ms[c] : 8'd0;
            end
            MODE_DIFF: begin
               side_in.simple[c] = (p1_ff.d[c] > p1_ff.ms[c]) ?
                                   p1_ff.d[c] - p1_ff.ms[c] : p1_ff.ms[c] - p1_ff.d[c];
            end
            MODE_DARKEN: begin
               side_in.simple[c] = (p1_ff.s[c] < p1_ff.d[c]) ? p1_ff.s[c] : p1_ff.d[c];
            end
            MODE_LIGHTEN: begin
               side_in.simple[c] = (p1_ff.s[c] > p1_ff.d[c]) ? p1_ff.s[c] : p1_ff.d[c];
            end
            MODE_MULT: begin
               t9 = 9'(mul8(p1_ff.d[c], p1_ff.ms[c])) + 9'(p1_ff.md[c]);
               side_in.simple[c] = t9[8] ? 8'd255 : t9[7:0];
            end
            MODE_SCREEN: begin
               side_in.simple[c] = p1_ff.scr[c];
            end
            MODE_OVERLAY: begin
               ov = 17'(p1_ff.d[c]) * 17'(p1_ff.scr[c]) +
                    17'(8'd255 - p1_ff.d[c]) * 17'(p1_ff.mc[c]);
               side_in.simple[c] = ov[15:8];
            end
            default: begin
               side_in.simple[c] = p1_ff.d[c];
            end
         endcase
      end

      // source recolor for divide mode; quotient of 256 or more saturates
      for (int c = 0; c < 3; c++) begin
         side_in.rc_hi[c] = p1_ff.d[c] > p1_ff.s[c];
         rc_lane[c].num   = {8'b0, p1_ff.d[c], 8'b0};
         rc_lane[c].den   = 17'(p1_ff.s[c]) + 17'd1;
         if (side_in.rc_hi[c]) rc_lane[c] = DIV_NOP;
      end

      for (int k = 0; k < 4; k++) lane_in[k] = DIV_NOP;
      case (p1_ff.mode) inside
         MODE_DIV: begin
            for (int c = 0; c < 3; c++) lane_in[c] = rc_lane[c];
         end
         MODE_HUE, MODE_SAT, MODE_VALUE: begin
            lane_in[0] = hue_lane(p1_ff.s, p1_ff.smx, p1_ff.smn);
            lane_in[1] = hue_lane(p1_ff.d, p1_ff.dmx, p1_ff.dmn);
            lane_in[2] = hsv_sat_lane(p1_ff.smx, p1_ff.smn);
            lane_in[3] = hsv_sat_lane(p1_ff.dmx, p1_ff.dmn);
         end
         MODE_COLOR: begin
            lane_in[0] = hue_lane(p1_ff.s, p1_ff.smx, p1_ff.smn);
            lane_in[2] = hls_sat_lane(p1_ff.smx, p1_ff.smn);
         end
         default: begin
         end
      endcase

      side_in.mode = p1_ff.mode;
      side_in.src  = p1_ff.s;
      side_in.dst  = p1_ff.d;
      side_in.sa   = p1_ff.sa;
      side_in.da   = p1_ff.da;
      side_in.na   = p1_ff.na;
      side_in.smx  = p1_ff.smx;
      side_in.dmx  = p1_ff.dmx;
      side_in.dsum = 9'(p1_ff.dmx) + 9'(p1_ff.dmn);
   end

   always_ff @(posedge clock) begin
      if (adv.p1) begin
         p1_ff <= p1_in;
      end
      if (adv.p2) begin
         side_ff <= side_in;
         lane_ff <= lane_in;
      end
   end

   assign side = side_ff;
   assign lane = lane_ff;

endmodule

// File: design/lbpc_recon.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpc_recon
// Middle stages: picks the colour-space bytes, builds the back-conversion
// and compositing operands of the second divider round.
// ----------------------------------------------------------------------------
module lbpc_recon import lbpc_pkg::*; (
   input  logic              clock,
   input  adv_type           adv,
   input  side1_type         side_in,
   input  logic [3:0][7:0]   q1,
   output side2_type         side_out,
   output div_in_type [2:0]  lane
);

   typedef struct packed {
      logic [3:0]  mode;
      rgb_type     es;
      rgb_type     d;
      logic [7:0]  sa;
      logic [7:0]  da;
      logic [7:0]  na;
      rgb_type     simple;
      logic [2:0]  sector;
      logic [7:0]  hsat;
      logic [7:0]  v;
      logic [15:0] sf;
      logic [15:0] sg;
      logic [7:0]  hh;
      logic [7:0]  l;
      logic [7:0]  hs;
      logic [16:0] m1;
      logic [16:0] m2;
   } p3_type;

   p3_type            p3_ff, p3_in;
   side2_type         side_ff, side_nx;
   div_in_type [2:0]  lane_ff, lane_in;

   logic [7:0]         h;
   logic [10:0]        h6;
   logic [7:0]         f;
   logic [15:0]        ls;
   logic signed [9:0]  nd;
   logic signed [19:0] nm;

   // one HLS channel, hue offset already applied
   function automatic div_in_type hls_lane(input logic [16:0] m1, input logic [16:0] m2,
                                           input logic signed [9:0] hue_raw);
      div_in_type        r;
      logic signed [9:0] hue;
      logic [7:0]        hb;
      logic [16:0]       dm;
      hue = hue_raw;
      if (hue > 10'sd255)
         hue = hue - 10'sd255;
      else if (hue < 10'sd0)
         hue = hue + 10'sd255;
      hb = hue[7:0];
      dm = m2 - m1;
      if (hb <= 8'd42) begin
         r.num = 24'(m1) * 24'd85 + ((24'(hb) * 24'(dm)) << 1);
         r.den = 17'd21675;
      end else if (hb <= 8'd127) begin
         r.num = 24'(m2);
         r.den = 17'd255;
      end else if (hb < 8'd170) begin
         r.num = 24'(m1) * 24'd85 + ((24'(8'd170 - hb) * 24'(dm)) << 1);
         r.den = 17'd21675;
      end else begin
         r.num = 24'(m1);
         r.den = 17'd255;
      end
      return r;
   endfunction

   // stage 3
   always_comb begin
      p3_in.mode   = side_in.mode;
      p3_in.d      = side_in.dst;
      p3_in.sa     = side_in.sa;
      p3_in.da     = side_in.da;
      p3_in.na     = side_in.na;
      p3_in.simple = side_in.simple;
      for (int c = 0; c < 3; c++) begin
         if (side_in.mode == MODE_DIV)
            p3_in.es[c] = side_in.rc_hi[c] ? 8'd255 : q1[c];
         else
            p3_in.es[c] = side_in.src[c];
      end

      // HSV: destination bytes with one byte taken from the source
      h          = (side_in.mode == MODE_HUE)   ? q1[0] : q1[1];
      p3_in.hsat = (side_in.mode == MODE_SAT)   ? q1[2] : q1[3];
      p3_in.v    = (side_in.mode == MODE_VALUE) ? side_in.smx : side_in.dmx;
      h6 = 11'(h) * 11'd6;
      p3_in.sector = 3'(h6 >= 11'd255) + 3'(h6 >= 11'd510) + 3'(h6 >= 11'd765) +
                     3'(h6 >= 11'd1020) + 3'(h6 >= 11'd1275);
      f = 8'(h6 - 11'(p3_in.sector) * 11'd255);
      p3_in.sf = 16'(p3_in.hsat) * 16'(f);
      p3_in.sg = 16'(p3_in.hsat) * 16'(8'd255 - f);

      // HLS: source hue and saturation, destination lightness
      p3_in.hh = q1[0];
      p3_in.hs = q1[2];
      p3_in.l  = side_in.dsum[8:1];
      ls = 16'(p3_in.l) * 16'(p3_in.hs);
      if (p3_in.l < 8'd128)
         p3_in.m2 = 17'(p3_in.l) * 17'd255 + 17'(ls);
      else
         p3_in.m2 = 17'(p3_in.l) * 17'd255 + 17'(p3_in.hs) * 17'd255 - 17'(ls);
      p3_in.m1 = 17'(p3_in.l) * 17'd510 - p3_in.m2;
   end

   // stage 4
   always_comb begin
      side_nx.mode     = p3_ff.mode;
      side_nx.dst      = p3_ff.d;
      side_nx.da       = p3_ff.da;
      side_nx.na       = p3_ff.na;
      side_nx.sa_zero  = (p3_ff.sa == 8'd0);
      side_nx.simple   = p3_ff.simple;
      side_nx.hi       = '0;
      side_nx.sector   = p3_ff.sector;
      side_nx.flat     = 1'b0;
      side_nx.flat_val = p3_ff.v;
      nd = '0;
      nm = '0;
      for (int k = 0; k < 3; k++) lane_in[k] = DIV_NOP;

      case (p3_ff.mode) inside
         MODE_NORMAL, MODE_DIV: begin
            nd = $signed({2'b0, p3_ff.na}) - $signed({2'b0, p3_ff.sa});
            for (int c = 0; c < 3; c++) begin
               nm = $signed({4'b0, 16'(p3_ff.es[c]) * 16'(p3_ff.sa)}) +
                    $signed({12'b0, p3_ff.d[c]}) * 20'(nd);
               if (nm < 0) begin
                  lane_in[c] = DIV_NOP;
               end else if (nm >= $signed({4'b0, p3_ff.na, 8'b0})) begin
                  side_nx.hi[c] = 1'b1;
                  lane_in[c]    = DIV_NOP;
               end else begin
                  lane_in[c].num = {7'b0, nm[16:0]};
                  lane_in[c].den = 17'(p3_ff.na);
               end
            end
         end
         MODE_HUE, MODE_SAT, MODE_VALUE: begin
            side_nx.flat   = (p3_ff.hsat == 8'd0);
            lane_in[0].num = 24'(p3_ff.v) * 24'(8'd255 - p3_ff.hsat);
            lane_in[0].den = 17'd255;
            lane_in[1].num = 24'(p3_ff.v) * 24'(17'd65025 - 17'(p3_ff.sf));
            lane_in[1].den = 17'd65025;
            lane_in[2].num = 24'(p3_ff.v) * 24'(17'd65025 - 17'(p3_ff.sg));
            lane_in[2].den = 17'd65025;
         end
         MODE_COLOR: begin
            side_nx.flat     = (p3_ff.hs == 8'd0);
            side_nx.flat_val = p3_ff.l;
            lane_in[0] = hls_lane(p3_ff.m1, p3_ff.m2, $signed({2'b0, p3_ff.hh}) + 10'sd85);
            lane_in[1] = hls_lane(p3_ff.m1, p3_ff.m2, $signed({2'b0, p3_ff.hh}));
            lane_in[2] = hls_lane(p3_ff.m1, p3_ff.m2, $signed({2'b0, p3_ff.hh}) - 10'sd85);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv.p3) begin
         p3_ff <= p3_in;
      end
      if (adv.p4) begin
         side_ff <= side_nx;
         lane_ff <= lane_in;
      end
   end

   assign side_out = side_ff;
   assign lane     = lane_ff;

endmodule

// File: design/layer_blend_pixel_combiner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layer_blend_pixel_combiner
// Pipeline: an accepted req word becomes its rsp word in the output register
// through two front stages, two divider stages, two middle stages, two
// divider stages and the output select.
// Throughput: one pixel pair per clock; every stage is registered with its
// own valid bit, so bubbles collapse and a stalled rsp holds only the words
// that cannot move.
// Reset: synchronous, active high; clears the valid bits and sets the blend
// mode to normal. Data registers are not reset.
// ----------------------------------------------------------------------------
module layer_blend_pixel_combiner import lbpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // pixel pair in
   input  logic        req_tvalid,
   output logic        req_tready,
   // src_red, src_green, src_blue, src_opacity, dst_red, dst_green, dst_blue,
   // dst_alpha, 8 bits each from bit 0 up
   input  logic [63:0] req_tdata,
   // blended pixel out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_red, out_green, out_blue, out_alpha, 8 bits each from bit 0 up
   output logic [31:0] rsp_tdata,
   // blend mode register
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);

   // -------------------------------------------------------------------------
   // Mode register. Sampled as a word enters stage 1 and carried with it.
   // -------------------------------------------------------------------------
   logic [3:0] blend_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff <= MODE_NORMAL;
      end else if (csr_wr_en) begin
         blend_mode_ff <= csr_wr_data;
      end
   end

   // -------------------------------------------------------------------------
   // Pipeline flow control. A stage loads when it is empty or when its word
   // moves on; the chain starts at the rsp side.
   // -------------------------------------------------------------------------
   logic [NUM_STG-1:0] vld_ff, vld_in;
   logic [NUM_STG:0]   go;
   adv_type            adv;

   always_comb begin
      go[NUM_STG] = rsp_tready;
      for (int k = NUM_STG - 1; k >= 0; k--) begin
         go[k] = !vld_ff[k] || go[k+1];
      end
      vld_in[0] = go[0] ? req_tvalid : vld_ff[0];
      for (int k = 1; k < NUM_STG; k++) begin
         vld_in[k] = go[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign adv.p1  = go[0];
   assign adv.p2  = go[1];
   assign adv.d1a = go[2];
   assign adv.d1b = go[3];
   assign adv.p3  = go[4];
   assign adv.p4  = go[5];
   assign adv.d2a = go[6];
   assign adv.d2b = go[7];
   assign adv.p5  = go[8];

   assign req_tready = go[0];
   assign rsp_tvalid = vld_ff[NUM_STG-1];

   // -------------------------------------------------------------------------
   // Unpack the req word
   // -------------------------------------------------------------------------
   rgb_type    src_pix, dst_pix;
   logic [7:0] src_opacity, dst_alpha;

   assign src_pix[0]  = req_tdata[7:0];
   assign src_pix[1]  = req_tdata[15:8];
   assign src_pix[2]  = req_tdata[23:16];
   assign src_opacity = req_tdata[31:24];
   assign dst_pix[0]  = req_tdata[39:32];
   assign dst_pix[1]  = req_tdata[47:40];
   assign dst_pix[2]  = req_tdata[55:48];
   assign dst_alpha   = req_tdata[63:56];

   // -------------------------------------------------------------------------
   // Stages 1-2: simple modes, extremes, first-round divider operands.
   // Lanes 0-2 recolor in divide mode; in the HSV modes lanes 0-3 carry source
   // hue, destination hue, source and destination saturation; colour: lanes 0, 2.
   // -------------------------------------------------------------------------
   side1_type        side1;
   div_in_type [3:0] lane1;

   lbpc_prep u_prep (
      .clock       (clock),
      .adv         (adv),
      .mode        (blend_mode_ff),
      .src         (src_pix),
      .src_opacity (src_opacity),
      .dst         (dst_pix),
      .dst_alpha   (dst_alpha),
      .side        (side1),
      .lane        (lane1)
   );

   // -------------------------------------------------------------------------
   // Stages 3-4: first divider round, sideband follows in step
   // -------------------------------------------------------------------------
   logic [3:0][7:0] q1;
   side1_type       side1_a_ff, side1_b_ff;

   for (genvar i = 0; i < 4; i++) begin : g_div1
      lbpc_div u_div (
         .clock (clock),
         .adv_a (adv.d1a),
         .adv_b (adv.d1b),
         .din   (lane1[i]),
         .quo   (q1[i])
      );
   end

   always_ff @(posedge clock) begin
      if (adv.d1a) side1_a_ff <= side1;
      if (adv.d1b) side1_b_ff <= side1_a_ff;
   end

   // -------------------------------------------------------------------------
   // Stages 5-6: HSV/HLS back conversion terms and compositing numerators
   // -------------------------------------------------------------------------
   side2_type        side2;
   div_in_type [2:0] lane2;

   lbpc_recon u_recon (
      .clock    (clock),
      .adv      (adv),
      .side_in  (side1_b_ff),
      .q1       (q1),
      .side_out (side2),
      .lane     (lane2)
   );

   // -------------------------------------------------------------------------
   // Stages 7-8: second divider round
   // -------------------------------------------------------------------------
   logic [2:0][7:0] q2;
   side2_type       side2_a_ff, side2_b_ff;

   for (genvar i = 0; i < 3; i++) begin : g_div2
      lbpc_div u_div (
         .clock (clock),
         .adv_a (adv.d2a),
         .adv_b (adv.d2b),
         .din   (lane2[i]),
         .quo   (q2[i])
      );
   end

   always_ff @(posedge clock) begin
      if (adv.d2a) side2_a_ff <= side2;
      if (adv.d2b) side2_b_ff <= side2_a_ff;
   end

   // -------------------------------------------------------------------------
   // Stage 9: output select into the rsp register
   // -------------------------------------------------------------------------
   rgb_type    out_pix_ff, out_pix_in;
   logic [7:0] out_alpha_ff, out_alpha_in;
   logic [7:0] hv_p, hv_q, hv_t, hv_v;

   always_comb begin
      hv_p = q2[0];
      hv_q = q2[1];
      hv_t = q2[2];
      hv_v = side2_b_ff.flat_val;
      out_pix_in   = side2_b_ff.simple;
      out_alpha_in = side2_b_ff.da;
      case (side2_b_ff.mode) inside
         MODE_NORMAL, MODE_DIV: begin
            // transparent source leaves the destination untouched
            if (side2_b_ff.sa_zero) begin
               out_pix_in = side2_b_ff.dst;
            end else begin
               for (int c = 0; c < 3; c++) begin
                  out_pix_in[c] = side2_b_ff.hi[c] ? 8'd255 : q2[c];
               end
               out_alpha_in = side2_b_ff.na;
            end
         end
         MODE_HUE, MODE_SAT, MODE_VALUE: begin
            if (side2_b_ff.flat) begin
               out_pix_in = {hv_v, hv_v, hv_v};
            end else begin
               case (side2_b_ff.sector)
                  3'd0:    out_pix_in = {hv_p, hv_t, hv_v};
                  3'd1:    out_pix_in = {hv_p, hv_v, hv_q};
                  3'd2:    out_pix_in = {hv_t, hv_v, hv_p};
                  3'd3:    out_pix_in = {hv_v, hv_q, hv_p};
                  3'd4:    out_pix_in = {hv_v, hv_p, hv_t};
                  default: out_pix_in = {hv_q, hv_p, hv_v};
               endcase
            end
         end
         MODE_COLOR: begin
            if (side2_b_ff.flat) begin
               out_pix_in = {hv_v, hv_v, hv_v};
            end else begin
               out_pix_in = q2;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv.p5) begin
         out_pix_ff   <= out_pix_in;
         out_alpha_ff <= out_alpha_in;
      end
   end

   assign rsp_tdata = {out_alpha_ff, out_pix_ff[2], out_pix_ff[1], out_pix_ff[0]};

endmodule
